@@ rtl/bhd_pkg.sv @@
// Package for the BER header decoder: beat types, phase encoding, status codes.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package bhd_pkg;

    // One input beat: a header octet and the buffer bytes that follow it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] bytes_after;
    } in_beat_t;

    // One result beat: the decoded header or the reason it failed.
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  tag_class;
        logic        constructed;
        logic [31:0] tag_number;
        logic        definite_length;
        logic [31:0] content_length;
    } out_beat_t;

    // Decoder phase within one header.
    typedef enum logic [1:0] {
        PH_IDENT    = 2'd0,
        PH_HIGH_TAG = 2'd1,
        PH_LEN_HEAD = 2'd2,
        PH_LEN_LONG = 2'd3
    } phase_t;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_PRIM_INDF = 2'd3;

    // Octet constants.
    localparam logic [4:0] HIGH_TAG_MARK = 5'h1F;
    localparam logic [7:0] LEN_INDEF     = 8'h80;

endpackage

`default_nettype wire

@@ rtl/bhd_in_reg.sv @@
// Input register of the BER header decoder: holds one accepted beat until decoded.
// Depends on bhd_pkg for the input beat type.
`default_nettype none

module bhd_in_reg (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bhd_pkg::in_beat_t s_data,
    input  wire logic            take,
    output logic                 held_valid,
    output bhd_pkg::in_beat_t    held_beat
);

    logic              valid_reg;
    logic              valid_next;
    bhd_pkg::in_beat_t beat_reg;

    // The register frees up in the same cycle its beat is decoded.
    assign s_ready    = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bhd_step.sv @@
// Decode step of the BER header decoder: phase machine and tag/length accumulators.
// Depends on bhd_pkg for beat types, phase encoding and status codes.
`default_nettype none

module bhd_step (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire bhd_pkg::in_beat_t beat,
    output logic                   emit,
    output bhd_pkg::out_beat_t     result
);

    bhd_pkg::phase_t phase_reg;
    bhd_pkg::phase_t phase_next;
    logic [31:0]     tag_reg;
    logic [31:0]     tag_next;
    logic [1:0]      class_reg;
    logic [1:0]      class_next;
    logic            cons_reg;
    logic            cons_next;
    logic [31:0]     len_reg;
    logic [31:0]     len_next;
    logic [6:0]      left_reg;
    logic [6:0]      left_next;

    logic [7:0]      b;
    logic [31:0]     after;
    logic            no_more;
    logic            len_done;
    logic [31:0]     long_len;

    assign b        = beat.data_byte;
    assign after    = beat.bytes_after;
    assign no_more  = (after == 32'd0);
    assign long_len = {len_reg[23:0], b};
    assign len_done = (left_reg <= 7'd1);

    // Next phase. Any beat that produces a result returns to the identifier phase.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            bhd_pkg::PH_IDENT: begin
                if (no_more) begin
                    phase_next = bhd_pkg::PH_IDENT;
                end else if (b[4:0] == bhd_pkg::HIGH_TAG_MARK) begin
                    phase_next = bhd_pkg::PH_HIGH_TAG;
                end else begin
                    phase_next = bhd_pkg::PH_LEN_HEAD;
                end
            end
            bhd_pkg::PH_HIGH_TAG: begin
                if (no_more) begin
                    phase_next = bhd_pkg::PH_IDENT;
                end else if (!b[7]) begin
                    phase_next = bhd_pkg::PH_LEN_HEAD;
                end
            end
            bhd_pkg::PH_LEN_HEAD: begin
                if (b[7] && (b != bhd_pkg::LEN_INDEF) && !no_more) begin
                    phase_next = bhd_pkg::PH_LEN_LONG;
                end else begin
                    phase_next = bhd_pkg::PH_IDENT;
                end
            end
            bhd_pkg::PH_LEN_LONG: begin
                if (len_done || no_more) begin
                    phase_next = bhd_pkg::PH_IDENT;
                end
            end
            default: begin
                phase_next = bhd_pkg::PH_IDENT;
            end
        endcase
    end

    // Accumulator updates and the result of this beat.
    always_comb begin
        tag_next   = tag_reg;
        class_next = class_reg;
        cons_next  = cons_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        emit       = 1'b0;
        result.status          = bhd_pkg::ST_EXHAUSTED;
        result.definite_length = 1'b0;
        result.content_length  = 32'd0;
        case (phase_reg)
            bhd_pkg::PH_IDENT: begin
                class_next = b[7:6];
                cons_next  = b[5];
                tag_next   = (b[4:0] == bhd_pkg::HIGH_TAG_MARK) ? 32'd0 : {27'd0, b[4:0]};
                emit       = no_more;
            end
            bhd_pkg::PH_HIGH_TAG: begin
                tag_next = {tag_reg[24:0], b[6:0]};
                emit     = no_more;
            end
            bhd_pkg::PH_LEN_HEAD: begin
                if (b == bhd_pkg::LEN_INDEF) begin
                    // Indefinite form is only legal for constructed encodings.
                    emit          = 1'b1;
                    result.status = cons_reg ? bhd_pkg::ST_OK : bhd_pkg::ST_PRIM_INDF;
                end else if (!b[7]) begin
                    // Short form length.
                    emit                   = 1'b1;
                    result.definite_length = 1'b1;
                    result.content_length  = {24'd0, b};
                    result.status = ({24'd0, b} > after) ? bhd_pkg::ST_TOO_LONG
                                                         : bhd_pkg::ST_OK;
                end else begin
                    // Long form header: count of length octets to follow.
                    left_next = b[6:0];
                    len_next  = 32'd0;
                    emit      = no_more;
                end
            end
            bhd_pkg::PH_LEN_LONG: begin
                len_next = long_len;
                if (len_done) begin
                    left_next              = 7'd0;
                    emit                   = 1'b1;
                    result.definite_length = 1'b1;
                    result.content_length  = long_len;
                    result.status = (long_len > after) ? bhd_pkg::ST_TOO_LONG
                                                       : bhd_pkg::ST_OK;
                end else begin
                    left_next = left_reg - 7'd1;
                    emit      = no_more;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        result.tag_class   = class_next;
        result.constructed = cons_next;
        result.tag_number  = tag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bhd_pkg::PH_IDENT;
            tag_reg   <= 32'd0;
            class_reg <= 2'd0;
            cons_reg  <= 1'b0;
            len_reg   <= 32'd0;
            left_reg  <= 7'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            class_reg <= class_next;
            cons_reg  <= cons_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ber_header_decoder_core.sv @@
// BER header decoder: takes one header octet per beat, together with the count of
// buffer bytes after it, and gives one result beat when an identifier-plus-length
// header completes or fails (buffer exhausted, length beyond the remaining bytes,
// or a primitive with indefinite length). It sustains one octet per clock cycle
// while the result channel does not stall it; a beat is held in the input register,
// from which the phase machine and the 32-bit tag and length accumulators update,
// and its result is registered in the output register, which drives m_valid.
// Octets that do not end a header give no result. Back-pressure on the result channel
// stalls decoding only while the output register is full.
// Depends on bhd_pkg, bhd_in_reg and bhd_step.
`default_nettype none

module ber_header_decoder_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bhd_pkg::in_beat_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output bhd_pkg::out_beat_t      m_data
);

    logic               held_valid;
    bhd_pkg::in_beat_t  held_beat;
    logic               advance;
    logic               emit;
    bhd_pkg::out_beat_t result;
    logic               out_valid_reg;
    logic               out_valid_next;
    bhd_pkg::out_beat_t out_beat_reg;

    // Decode the held beat whenever the output register has room.
    assign advance = held_valid && (!out_valid_reg || m_ready);

    bhd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (advance),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    bhd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .beat    (held_beat),
        .emit    (emit),
        .result  (result)
    );

    // Output register valid tracking.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_beat_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_beat_reg;

endmodule

`default_nettype wire

@@ bench/ber_header_decoder_checker.sv @@
`timescale 1ns / 1ps
// Checker for the BER header decoder: watches both beat channels, decodes the accepted
// octets on its own and compares each result beat with the oldest one it predicted.
// Depends on bhd_pkg for the beat types, phase encoding and status codes.

module ber_header_decoder_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  bhd_pkg::in_beat_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  bhd_pkg::out_beat_t m_data,
    output int                 mismatches,
    output int                 outstanding
);
    import bhd_pkg::*;

    // Decoder state as this checker tracks it.
    phase_t      hdr_phase;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [1:0]  class_seen;
    logic        cons_seen;
    logic [6:0]  len_left;

    // Result beats predicted but not yet seen on the output.
    out_beat_t results_due[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    // Advance the header decode by one octet; got is set when the octet ends the header or exhausts the buffer.
    task automatic decode_octet(input in_beat_t beat, output logic got, output out_beat_t res);
        logic [7:0]  octet;
        logic [31:0] after;
        logic        closing;
        logic        def;
        logic [31:0] len;
        octet   = beat.data_byte;
        after   = beat.bytes_after;
        closing = 1'b0;
        def     = 1'b0;
        len     = '0;
        case (hdr_phase)
            PH_IDENT: begin
                class_seen = octet[7:6];
                cons_seen  = octet[5];
                tag_acc    = {27'd0, octet[4:0]};
                if (octet[4:0] == HIGH_TAG_MARK) begin
                    tag_acc   = '0;
                    hdr_phase = PH_HIGH_TAG;
                end else begin
                    hdr_phase = PH_LEN_HEAD;
                end
            end
            PH_HIGH_TAG: begin
                // Base-128 digits, most significant first; the top bit marks continuation.
                tag_acc = {tag_acc[24:0], octet[6:0]};
                if (!octet[7]) begin
                    hdr_phase = PH_LEN_HEAD;
                end
            end
            PH_LEN_HEAD: begin
                if (octet == LEN_INDEF) begin
                    closing = 1'b1;
                end else if (!octet[7]) begin
                    closing = 1'b1;
                    def     = 1'b1;
                    len     = {24'd0, octet};
                end else begin
                    len_left  = octet[6:0];
                    len_acc   = '0;
                    hdr_phase = PH_LEN_LONG;
                end
            end
            default: begin
                // Long-form length octets, big-endian; the accumulator wraps at 32 bits.
                len_acc = {len_acc[23:0], octet};
                if (len_left <= 7'd1) begin
                    len_left = '0;
                    closing  = 1'b1;
                    def      = 1'b1;
                    len      = len_acc;
                end else begin
                    len_left = len_left - 7'd1;
                end
            end
        endcase

        got                 = 1'b1;
        res.tag_class       = class_seen;
        res.constructed     = cons_seen;
        res.tag_number      = tag_acc;
        res.definite_length = 1'b0;
        res.content_length  = '0;
        if (closing) begin
            // The length check takes precedence over the primitive indefinite check.
            if (def && len > after) begin
                res.status          = ST_TOO_LONG;
                res.definite_length = 1'b1;
                res.content_length  = len;
            end else if (!cons_seen && !def) begin
                res.status = ST_PRIM_INDF;
            end else begin
                res.status          = ST_OK;
                res.definite_length = def;
                res.content_length  = len;
            end
        end else if (after == 32'd0) begin
            res.status = ST_EXHAUSTED;
        end else begin
            got = 1'b0;
        end
        if (got) begin
            hdr_phase = PH_IDENT;
        end
    endtask

    // Compare result beats first, then record the prediction for the octet taken this edge.
    always @(posedge aclk) begin
        logic      got;
        out_beat_t res;
        out_beat_t want;
        if (!aresetn) begin
            hdr_phase  = PH_IDENT;
            tag_acc    = '0;
            len_acc    = '0;
            class_seen = '0;
            cons_seen  = 1'b0;
            len_left   = '0;
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("%0t: result beat with nothing expected: %p", $realtime, m_data);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (m_data.status !== want.status
                            || m_data.tag_class !== want.tag_class
                            || m_data.constructed !== want.constructed
                            || m_data.tag_number !== want.tag_number
                            || m_data.definite_length !== want.definite_length
                            || m_data.content_length !== want.content_length) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected %p", want);
                            $display("    actual   %p", m_data);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_octet(s_data, got, res);
                if (got) begin
                    results_due.push_back(res);
                end
            end
        end
        outstanding = results_due.size();
    end

endmodule

@@ bench/ber_header_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the BER header decoder bench: clock, reset, octet stimulus and result back-pressure.
// Depends on bhd_pkg, ber_header_decoder_core and ber_header_decoder_checker.

module ber_header_decoder_core_tb;
    import bhd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_OCTETS = 600;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    int mismatches;
    int outstanding;
    int cycles      = 0;
    int burst_left  = 0;
    int octets_sent = 0;
    int ready_mode  = 0;
    int ready_count = 0;

    ber_header_decoder_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    ber_header_decoder_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver switches among stall patterns, picked at random.
    always @(negedge aclk) begin
        ready_count <= ready_count + 1;
        if (ready_count % 64 == 0) begin
            ready_mode <= $urandom_range(0, 3);
        end
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (ready_count % 5 != 0);
        endcase
    end

    // Present one octet beat and hold it until it is taken; returns at a falling edge.
    task automatic send_octet(input logic [7:0] octet, input logic [31:0] after);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: octet, bytes_after: after};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left  = burst_left - 1;
        octets_sent = octets_sent + 1;
        @(negedge aclk);
    endtask

    // Hold the sender off until every predicted result beat has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Remaining byte count for an octet that does not end the header.
    function automatic logic [31:0] remaining_count(input int zero_odds);
        if (zero_odds > 0 && $urandom_range(1, zero_odds) == 1) begin
            return 32'd0;
        end
        if ($urandom_range(0, 2) == 0) begin
            return $urandom;
        end
        return $urandom_range(1, 300);
    endfunction

    // Remaining byte count for the last length octet, often right at the boundary.
    function automatic logic [31:0] length_margin(input logic [31:0] len);
        case ($urandom_range(0, 4))
            0: return len;
            1: return len - 32'd1;
            2: return len + $urandom_range(1, 3);
            3: return $urandom;
            default: return remaining_count(3);
        endcase
    endfunction

    // One well-formed header with random content: identifier, tag digits, length.
    task automatic send_header();
        logic [7:0]  ident;
        logic [7:0]  octet;
        logic [31:0] len;
        int          n_tag;
        int          n_len;
        int          pick;
        int          zero_odds;
        ident = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            ident[4:0] = HIGH_TAG_MARK;
        end
        send_octet(ident, remaining_count(16));
        if (ident[4:0] == HIGH_TAG_MARK) begin
            n_tag = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            for (int i = 0; i < n_tag; i++) begin
                octet    = 8'($urandom);
                octet[7] = (i != n_tag - 1);
                send_octet(octet, remaining_count(16));
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            octet = 8'($urandom_range(0, 127));
            send_octet(octet, length_margin({24'd0, octet}));
        end else if (pick < 6) begin
            send_octet(LEN_INDEF, remaining_count(4));
        end else begin
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                n_len = 127;
            end else if (pick < 6) begin
                n_len = $urandom_range(5, 8);
            end else begin
                n_len = $urandom_range(1, 4);
            end
            zero_odds = (n_len == 127) ? 0 : 16;
            send_octet({1'b1, 7'(n_len)}, remaining_count(zero_odds));
            len = '0;
            for (int i = 0; i < n_len; i++) begin
                octet = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
                len   = {len[23:0], octet};
                if (i == n_len - 1) begin
                    send_octet(octet, length_margin(len));
                end else begin
                    send_octet(octet, remaining_count(zero_odds));
                end
            end
        end
    endtask

    initial begin
        logic paused;
        paused = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Primitive with a short-form length equal to the bytes left.
        send_octet(8'h02, 32'd10);
        send_octet(8'h05, 32'd5);
        // Private constructed element with a two-octet high tag and indefinite length.
        send_octet(8'hFF, 32'd50);
        send_octet(8'h81, 32'd49);
        send_octet(8'h7F, 32'd48);
        send_octet(LEN_INDEF, 32'd47);
        // High tag of value zero on a primitive with indefinite length.
        send_octet(8'h1F, 32'd9);
        send_octet(8'h00, 32'd8);
        send_octet(LEN_INDEF, 32'd7);
        // Long-form length larger than the bytes that remain.
        send_octet(8'h30, 32'd300);
        send_octet(8'h82, 32'd299);
        send_octet(8'h01, 32'd298);
        send_octet(8'h2C, 32'd3);
        // Buffer runs out right after the identifier.
        send_octet(8'h44, 32'd0);
        // Context class, largest low tag, largest short-form length.
        send_octet(8'h9E, 32'd200);
        send_octet(8'h7F, 32'd127);
        // Zero length as the very last byte of the buffer.
        send_octet(8'h05, 32'd1);
        send_octet(8'h00, 32'd0);
        // Largest four-octet length with every bit of the remaining count set.
        send_octet(8'hE0, 32'd100);
        send_octet(8'h84, 32'd99);
        send_octet(8'hFF, 32'd98);
        send_octet(8'hFF, 32'd97);
        send_octet(8'hFF, 32'd96);
        send_octet(8'hFF, 32'hFFFF_FFFF);
        drain_results();

        // Random headers, with occasional runs of arbitrary octets in between.
        octets_sent = 0;
        while (octets_sent < RANDOM_OCTETS) begin
            if (!paused && octets_sent >= RANDOM_OCTETS / 2) begin
                paused = 1'b1;
                drain_results();
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3)) send_octet(8'($urandom), remaining_count(4));
            end else begin
                send_header();
            end
        end

        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
